/* hw/rtl/bawc_pkg.sv */
// ----------------------------------------------------------------------------
// Bus access wait-cycle package
// Shared types, register indexes, address constants and size-indexed cost
// tables for the bus access wait-cycle decoder.
// ----------------------------------------------------------------------------
package bawc_pkg;

    // Field widths.
    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 2;
    localparam int COST_W  = 10;
    localparam int MODE_W  = 2;
    localparam int FLASH_W = 26;
    localparam int DATA_W  = 26;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_PLATFORM_MODE = 1'b0,
        REG_FLASH_BYTES   = 1'b1
    } reg_index_t;

    // Platform mode codes.
    localparam logic [MODE_W-1:0] MODE_CONSOLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BOARD_A = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOARD_B = 2'd2;

    // Access size codes.
    localparam logic [SIZE_W-1:0] SIZE_BYTE  = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_HALF  = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_WORD  = 2'd2;
    localparam logic [SIZE_W-1:0] SIZE_BURST = 2'd3;

    // Action codes.
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Register reset values.
    localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_CONSOLE;
    localparam logic [FLASH_W-1:0] FLASH_RESET = 26'd131072;

    // Address constants.
    localparam logic [ADDR_W-1:0] SQ_MASK   = 32'hfc000000;
    localparam logic [ADDR_W-1:0] SQ_BASE   = 32'he0000000;
    localparam logic [26:0]       ROM_END   = 27'h0200000;
    localparam logic [28:0]       BOOT_B_END = 29'h0020000;

    // Largest cost any access can produce.
    localparam logic [COST_W-1:0] COST_MAX = 10'd618;

    // Configuration registers as seen by the decoder.
    typedef struct packed {
        logic [MODE_W-1:0]  platform_mode;
        logic [FLASH_W-1:0] flash_bytes;
    } cfg_t;

    // Boot ROM read cost by size.
    function automatic logic [COST_W-1:0] rom_read_cost(input logic [SIZE_W-1:0] sz);
        logic [COST_W-1:0] c;
        case (sz)
            SIZE_BYTE: c = 10'd44;
            SIZE_HALF: c = 10'd63;
            SIZE_WORD: c = 10'd99;
            default:   c = 10'd618;
        endcase
        return c;
    endfunction

    // Flash read cost by size.
    function automatic logic [COST_W-1:0] flash_read_cost(input logic [SIZE_W-1:0] sz);
        logic [COST_W-1:0] c;
        case (sz)
            SIZE_BYTE: c = 10'd41;
            SIZE_HALF: c = 10'd55;
            SIZE_WORD: c = 10'd83;
            default:   c = 10'd489;
        endcase
        return c;
    endfunction

    // External area read cost by size.
    function automatic logic [COST_W-1:0] ext_read_cost(input logic [SIZE_W-1:0] sz);
        logic [COST_W-1:0] c;
        case (sz)
            SIZE_BYTE: c = 10'd56;
            SIZE_HALF: c = 10'd56;
            SIZE_WORD: c = 10'd60;
            default:   c = 10'd84;
        endcase
        return c;
    endfunction

    // Sound area read cost by size, scaled by the byte count.
    function automatic logic [COST_W-1:0] sound_read_cost(input logic [SIZE_W-1:0] sz);
        logic [COST_W-1:0] c;
        case (sz)
            SIZE_BYTE: c = 10'd10;
            SIZE_HALF: c = 10'd20;
            SIZE_WORD: c = 10'd40;
            default:   c = 10'd320;
        endcase
        return c;
    endfunction

    // Sound area write cost by size, scaled by the byte count.
    function automatic logic [COST_W-1:0] sound_write_cost(input logic [SIZE_W-1:0] sz);
        logic [COST_W-1:0] c;
        case (sz)
            SIZE_BYTE: c = 10'd3;
            SIZE_HALF: c = 10'd6;
            SIZE_WORD: c = 10'd12;
            default:   c = 10'd96;
        endcase
        return c;
    endfunction

endpackage

/* hw/rtl/bawc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Bus access wait-cycle configuration registers
// Holds the platform mode and the flash size, written through a plain
// write-enable port.
// ----------------------------------------------------------------------------
module bawc_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [bawc_pkg::DATA_W-1:0]  cfg_wdata,
    output bawc_pkg::cfg_t               cfg
);

    logic [bawc_pkg::MODE_W-1:0]  mode_reg;
    logic [bawc_pkg::FLASH_W-1:0] flash_reg;

    // Register file write decode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= bawc_pkg::MODE_RESET;
            flash_reg <= bawc_pkg::FLASH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bawc_pkg::REG_PLATFORM_MODE: mode_reg  <= cfg_wdata[bawc_pkg::MODE_W-1:0];
                bawc_pkg::REG_FLASH_BYTES:   flash_reg <= cfg_wdata[bawc_pkg::FLASH_W-1:0];
                default:                     mode_reg  <= mode_reg;
            endcase
        end
    end

    assign cfg.platform_mode = mode_reg;
    assign cfg.flash_bytes   = flash_reg;

endmodule

/* hw/rtl/bawc_decode.sv */
// ----------------------------------------------------------------------------
// Bus access wait-cycle address decoder
// Maps one access (action, address, size) to its external wait-cycle cost,
// using the current platform mode and flash size.
// ----------------------------------------------------------------------------
module bawc_decode (
    input  bawc_pkg::cfg_t               cfg,
    input  logic                         action,
    input  logic [bawc_pkg::ADDR_W-1:0]  address,
    input  logic [bawc_pkg::SIZE_W-1:0]  access_size,
    output logic [bawc_pkg::COST_W-1:0]  wait_cycles
);

    logic                        board_b;
    logic                        arcade;
    logic                        store_queue;
    logic [28:0]                 a;
    logic [2:0]                  area;
    logic [24:0]                 m;
    logic [26:0]                 flash_end;
    logic                        below_rom;
    logic                        below_boot_b;
    logic                        below_flash;
    logic                        burst;
    logic                        win_a;
    logic                        win_b;
    logic                        win_c;
    logic                        win_d;
    logic                        win_e;
    logic                        win_f;
    logic                        win_fifo;
    logic                        win_extra;
    logic                        win_sound;
    logic                        win_ext;
    logic [bawc_pkg::COST_W-1:0] rd_cost;
    logic [bawc_pkg::COST_W-1:0] wr_cost;

    // Platform and address fields.
    always_comb
    begin
        board_b      = (cfg.platform_mode == bawc_pkg::MODE_BOARD_B);
        arcade       = (cfg.platform_mode == bawc_pkg::MODE_BOARD_A) || board_b;
        store_queue  = ((address & bawc_pkg::SQ_MASK) == bawc_pkg::SQ_BASE);
        a            = address[28:0];
        area         = a[28:26];
        m            = a[24:0];
        burst        = (access_size == bawc_pkg::SIZE_BURST);
        flash_end    = bawc_pkg::ROM_END + {1'b0, cfg.flash_bytes};
        below_rom    = (a < {2'b00, bawc_pkg::ROM_END});
        below_boot_b = (a < bawc_pkg::BOOT_B_END);
        below_flash  = (a < {2'b00, flash_end});
    end

    // Register, sound and external windows inside area 0.
    always_comb
    begin
        win_a     = (m >= 25'h05f6800) && (m <= 25'h05f69ff);
        win_b     = (m >= 25'h05f6c00) && (m <= 25'h05f6cff);
        win_c     = (m >= 25'h05f7000) && (m <= 25'h05f70ff);
        win_d     = (m >= 25'h05f7400) && (m <= 25'h05f74ff);
        win_e     = (m >= 25'h05f7800) && (m <= 25'h05f78ff);
        win_f     = (m >= 25'h05f7c00) && (m <= 25'h05f7cff);
        win_fifo  = (m >= 25'h05f8000) && (m <= 25'h05f9fff);
        win_extra = (m >= 25'h0600000) && (m <= 25'h06007ff);
        win_sound = (m >= 25'h0700000) && (m <= 25'h0ffffff);
        win_ext   = m[24];
    end

    // Read cost.
    always_comb
    begin
        rd_cost = 10'd60;
        case (area)
            3'd0:
            begin
                if (!board_b && below_rom)
                    rd_cost = bawc_pkg::rom_read_cost(access_size);
                else if ((!board_b && below_flash) ||
                         (board_b && (below_boot_b || (!below_rom && below_flash))))
                    rd_cost = bawc_pkg::flash_read_cost(access_size);
                else if (win_a)     rd_cost = 10'd5;
                else if (win_b)     rd_cost = 10'd22;
                else if (win_c)     rd_cost = arcade ? 10'd20 : 10'd39;
                else if (win_d)     rd_cost = 10'd24;
                else if (win_e)     rd_cost = 10'd38;
                else if (win_f)     rd_cost = 10'd24;
                else if (win_fifo)  rd_cost = 10'd34;
                else if (win_extra) rd_cost = board_b ? 10'd20 : 10'd67;
                else if (win_sound) rd_cost = bawc_pkg::sound_read_cost(access_size);
                else if (win_ext)   rd_cost = bawc_pkg::ext_read_cost(access_size);
                else                rd_cost = 10'd60;
            end
            3'd1: rd_cost = burst ? 10'd61 : 10'd41;
            3'd2: rd_cost = 10'd60;
            3'd3: rd_cost = 10'd7;
            // The upper half (a[24] set) reads slower than the lower half.
            3'd4: rd_cost = a[24] ? 10'd61 : 10'd60;
            3'd5: rd_cost = bawc_pkg::ext_read_cost(access_size);
            3'd6: rd_cost = 10'd60;
            default: rd_cost = 10'd0;
        endcase
        if (store_queue)
            rd_cost = 10'd0;
    end

    // Write cost.
    always_comb
    begin
        wr_cost = 10'd14;
        case (area)
            3'd0:
            begin
                if (!board_b && below_rom)                   wr_cost = 10'd99;
                else if (!board_b && below_flash)            wr_cost = 10'd28;
                else if (board_b && below_boot_b)            wr_cost = 10'd28;
                else if (board_b && !below_rom && below_flash) wr_cost = 10'd14;
                else if (win_a)     wr_cost = 10'd5;
                else if (win_b)     wr_cost = 10'd12;
                else if (win_c)     wr_cost = arcade ? 10'd14 : 10'd28;
                else if (win_d)     wr_cost = 10'd12;
                else if (win_e)     wr_cost = 10'd12;
                else if (win_f)     wr_cost = 10'd12;
                else if (win_fifo)  wr_cost = 10'd14;
                else if (win_extra) wr_cost = board_b ? 10'd14 : 10'd44;
                else if (win_sound) wr_cost = bawc_pkg::sound_write_cost(access_size);
                else if (win_ext)   wr_cost = burst ? 10'd52 : 10'd28;
                else                wr_cost = 10'd14;
            end
            3'd1: wr_cost = burst ? 10'd38 : 10'd12;
            3'd2: wr_cost = 10'd12;
            3'd3: wr_cost = 10'd4;
            // Area 4 splits on a[24] first: the upper 16 MB of each 32 MB half, then
            // the upper and lower 8 MB halves of the lower 16 MB.
            3'd4:
            begin
                if (a[24])      wr_cost = 10'd5;
                else if (a[23]) wr_cost = 10'd9;
                else            wr_cost = 10'd7;
            end
            3'd5: wr_cost = burst ? 10'd52 : 10'd28;
            3'd6: wr_cost = 10'd14;
            default: wr_cost = 10'd0;
        endcase
        if (store_queue)
            wr_cost = 10'd0;
    end

    assign wait_cycles = (action == bawc_pkg::ACT_WRITE) ? wr_cost : rd_cost;

endmodule

/* hw/rtl/bus_access_wait_cycles.sv */
// ----------------------------------------------------------------------------
// Bus access wait-cycle decoder, top level
// Registers each access request, decodes its external wait-cycle cost and
// holds the cost in an output register until it is taken.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  in        input      in_valid/in_ready    action, address, access_size
//  out       output     out_valid/out_ready  wait_cycles
//  cfg       input      cfg_we (no wait)     cfg_index, cfg_wdata
//
//  A request is registered on acceptance and its cost is then registered
//  in the output register: one request per cycle unless the output stalls.
//  The input register refills whenever the output register is empty or
//  being taken, so a stalled output holds at most two requests in flight.
//  Reset clears both valid flags and loads the configuration defaults.
// ----------------------------------------------------------------------------
module bus_access_wait_cycles (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         action,
    input  logic [bawc_pkg::ADDR_W-1:0]  address,
    input  logic [bawc_pkg::SIZE_W-1:0]  access_size,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [bawc_pkg::COST_W-1:0]  wait_cycles,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [bawc_pkg::DATA_W-1:0]  cfg_wdata
);

    bawc_pkg::cfg_t              cfg;
    logic                        s1_valid_reg;
    logic                        action_reg;
    logic [bawc_pkg::ADDR_W-1:0] address_reg;
    logic [bawc_pkg::SIZE_W-1:0] size_reg;
    logic                        out_valid_reg;
    logic [bawc_pkg::COST_W-1:0] cost_reg;
    logic [bawc_pkg::COST_W-1:0] cost_next;
    logic                        s2_ready;
    logic                        s1_load;

    // Configuration registers.
    bawc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Pipeline flow control.
    assign s2_ready = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s2_ready;
    assign s1_load  = in_valid && in_ready;

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            action_reg  <= action;
            address_reg <= address;
            size_reg    <= access_size;
        end
    end

    // Cost decode.
    bawc_decode u_decode (
        .cfg         (cfg),
        .action      (action_reg),
        .address     (address_reg),
        .access_size (size_reg),
        .wait_cycles (cost_next)
    );

    // Output register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_ready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
            cost_reg <= cost_next;
    end

    assign out_valid   = out_valid_reg;
    assign wait_cycles = cost_reg;

    // A request in the input register moves to the output when it has room.
    a_s1_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready) |=> out_valid_reg)
        else $error("registered request did not reach the output register");

    // A request is never accepted while both stages are full and stalled.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input accepted while pipeline is full");

    // Store-queue accesses cost nothing.
    a_sq_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_ready &&
         ((address_reg & bawc_pkg::SQ_MASK) == bawc_pkg::SQ_BASE))
        |=> (wait_cycles == '0))
        else $error("store-queue access produced a nonzero cost");

    // No cost exceeds the slowest boot ROM burst.
    a_cost_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (cost_reg <= bawc_pkg::COST_MAX))
        else $error("wait-cycle count out of range");

endmodule
